FILE: rtl/dppdf_pkg.sv
// Package for the depth patch pair-difference feature extractor.
// Holds payload structs, pattern codes, controller/datapath command types.
// No dependencies.
package dppdf_pkg;

  localparam int ImgWidth  = 256;
  localparam int ImgHeight = 256;
  localparam int DepthBits = 16;
  localparam int MaxPts    = 13;

  localparam logic [1:0] PAT_FOUR     = 2'd0;
  localparam logic [1:0] PAT_FIVE     = 2'd1;
  localparam logic [1:0] PAT_NINE     = 2'd2;
  localparam logic [1:0] PAT_THIRTEEN = 2'd3;

  localparam logic REG_PATTERN = 1'b0;
  localparam logic REG_SENS    = 1'b1;

  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [15:0] depth_value;
    logic [7:0] rect_x;
    logic [7:0] rect_y;
    logic [7:0] rect_width;
    logic [7:0] rect_height;
  } in_item_t;

  typedef struct packed {
    logic [15:0] feature_first;
    logic [15:0] feature_second;
    logic        out_of_range;
    logic        last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;      // capture the input item and compute points
    logic       rd_en;     // issue a store read for point rd_idx
    logic [3:0] rd_idx;
    logic       cap_en;    // capture read data into sample cap_idx
    logic [3:0] cap_idx;
    logic       div_start; // start a feature division for pair (pi, pj)
    logic [3:0] pi;
    logic [3:0] pj;
    logic       feat_lo;   // store the feature as first half of a result
    logic       emit;      // present the result
    logic       emit_last;
    logic       emit_oor;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [3:0] npts;
    logic       oor;
    logic       div_done;
  } dp_sts_t;

endpackage

FILE: rtl/dppdf_datapath.sv
// Datapath: depth store, sample point generation, sample registers,
// bit-serial divider for the features and the result register.
// Depends on dppdf_pkg.
module dppdf_datapath #(
  parameter int IMG_WIDTH  = dppdf_pkg::ImgWidth,
  parameter int IMG_HEIGHT = dppdf_pkg::ImgHeight,
  parameter int DEPTH_BITS = dppdf_pkg::DepthBits
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  dppdf_pkg::in_item_t  item,
  input  logic [1:0]           pattern,
  input  logic [15:0]          sens,
  input  dppdf_pkg::dp_cmd_t   cmd,
  output dppdf_pkg::dp_sts_t   sts,
  output logic                 out_strobe,
  output dppdf_pkg::out_item_t out_data
);

  localparam int XW = (IMG_WIDTH > 1) ? $clog2(IMG_WIDTH) : 1;
  localparam int YW = (IMG_HEIGHT > 1) ? $clog2(IMG_HEIGHT) : 1;
  localparam int AW = XW + YW;
  localparam int NPTS = dppdf_pkg::MaxPts;

  // Depth store, written and read with a registered read port.
  logic [DEPTH_BITS-1:0] mem [0:(1<<AW)-1];
  logic [DEPTH_BITS-1:0] rd_data_r;
  logic [AW-1:0]         rd_addr;

  // Sample points, 9-bit coordinates (up to 510).
  logic [8:0] px_r [0:NPTS-1];
  logic [8:0] py_r [0:NPTS-1];
  logic [8:0] px_nxt [0:NPTS-1];
  logic [8:0] py_nxt [0:NPTS-1];
  logic [3:0] npts_r, npts_nxt;
  logic       oor_nxt, oor_r;

  logic [DEPTH_BITS-1:0] dv_r [0:NPTS-1];

  // Write port of the store; writes outside the image are dropped.
  always_ff @(posedge clk) begin
    if (wr_en && ({5'd0, item.pixel_x} < 13'(IMG_WIDTH))
        && ({5'd0, item.pixel_y} < 13'(IMG_HEIGHT))) begin
      mem[{YW'(item.pixel_y), XW'(item.pixel_x)}] <=
        DEPTH_BITS'(item.depth_value);
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_addr = {YW'(py_r[cmd.rd_idx]), XW'(px_r[cmd.rd_idx])};

  // Point generation from the rectangle and the pattern.
  always_comb begin
    logic [8:0] x0, x1, x2, y0, y1, y2, w3, h3, qx0, qx1, qy0, qy1;
    logic [7:0] w2, h2;
    w3 = 9'((17'(item.rect_width) * 17'd171) >> 9);
    h3 = 9'((17'(item.rect_height) * 17'd171) >> 9);
    w2 = {1'b0, item.rect_width[7:1]};
    h2 = {1'b0, item.rect_height[7:1]};
    x0 = {1'b0, item.rect_x};
    y0 = {1'b0, item.rect_y};
    x1 = x0 + {1'b0, w2};
    y1 = y0 + {1'b0, h2};
    x2 = x0 + {1'b0, item.rect_width};
    y2 = y0 + {1'b0, item.rect_height};
    qx0 = x0 + {2'b0, w2[7:1]};
    qy0 = y0 + {2'b0, h2[7:1]};
    qx1 = x1 + ((x2 - x1) >> 1);
    qy1 = y1 + ((y2 - y1) >> 1);
    for (int k = 0; k < NPTS; k++) begin
      px_nxt[k] = '0;
      py_nxt[k] = '0;
    end
    unique case (pattern)
      dppdf_pkg::PAT_FOUR: begin
        px_nxt[0] = x0 + w3;        py_nxt[0] = y0 + h3;
        px_nxt[1] = x0 + (w3 << 1); py_nxt[1] = y0 + h3;
        px_nxt[2] = x0 + w3;        py_nxt[2] = y0 + (h3 << 1);
        px_nxt[3] = x0 + (w3 << 1); py_nxt[3] = y0 + (h3 << 1);
        npts_nxt = 4'd4;
      end
      dppdf_pkg::PAT_FIVE: begin
        px_nxt[0] = x0; py_nxt[0] = y0;
        px_nxt[1] = x2; py_nxt[1] = y0;
        px_nxt[2] = x0; py_nxt[2] = y2;
        px_nxt[3] = x2; py_nxt[3] = y2;
        px_nxt[4] = x1; py_nxt[4] = y1;
        npts_nxt = 4'd5;
      end
      default: begin
        px_nxt[0] = x0; py_nxt[0] = y0;
        px_nxt[1] = x1; py_nxt[1] = y0;
        px_nxt[2] = x2; py_nxt[2] = y0;
        px_nxt[3] = x0; py_nxt[3] = y1;
        px_nxt[4] = x1; py_nxt[4] = y1;
        px_nxt[5] = x2; py_nxt[5] = y1;
        px_nxt[6] = x0; py_nxt[6] = y2;
        px_nxt[7] = x1; py_nxt[7] = y2;
        px_nxt[8] = x2; py_nxt[8] = y2;
        px_nxt[9] = qx0;  py_nxt[9] = qy0;
        px_nxt[10] = qx1; py_nxt[10] = qy0;
        px_nxt[11] = qx0; py_nxt[11] = qy1;
        px_nxt[12] = qx1; py_nxt[12] = qy1;
        npts_nxt = (pattern == dppdf_pkg::PAT_THIRTEEN) ? 4'd13 : 4'd9;
      end
    endcase
    oor_nxt = 1'b0;
    for (int k = 0; k < NPTS; k++) begin
      if (4'(k) < npts_nxt && ({4'd0, px_nxt[k]} >= 13'(IMG_WIDTH) ||
          {4'd0, py_nxt[k]} >= 13'(IMG_HEIGHT))) begin
        oor_nxt = 1'b1;
      end
    end
  end

  // Point and sample registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < NPTS; k++) begin
        px_r[k] <= px_nxt[k];
        py_r[k] <= py_nxt[k];
      end
      npts_r <= npts_nxt;
      oor_r  <= oor_nxt;
    end
    if (cmd.cap_en) begin
      dv_r[cmd.cap_idx] <= rd_data_r;
    end
  end

  // Bit-serial restoring divider: q = min(|d|,s)*32768 / s, 31 steps.
  localparam int NW = 16 + 15;
  logic [NW-1:0] num_r;
  logic [16:0]   rem_r;
  logic [15:0]   quo_r;
  logic [15:0]   den_r;
  logic [4:0]    cnt_r;
  logic          busy_r, neg_r, done_r;
  logic [DEPTH_BITS:0] diff;
  logic [DEPTH_BITS-1:0] mag;
  logic [15:0]   s_eff, mag_c;
  logic [16:0]   trial;
  logic [16:0]   feat;

  assign diff  = {1'b0, dv_r[cmd.pi]} - {1'b0, dv_r[cmd.pj]};
  assign mag   = diff[DEPTH_BITS] ? DEPTH_BITS'(-diff) : diff[DEPTH_BITS-1:0];
  assign s_eff = (sens == 16'd0) ? 16'd1 : sens;
  assign mag_c = (32'(mag) > 32'(s_eff)) ? s_eff : 16'(mag);
  assign trial = {rem_r[15:0], num_r[NW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.div_start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
        num_r  <= {mag_c, 15'd0};
        rem_r  <= '0;
        quo_r  <= '0;
        den_r  <= s_eff;
        neg_r  <= diff[DEPTH_BITS];
      end else if (busy_r) begin
        num_r <= num_r << 1;
        if (trial >= {1'b0, den_r}) begin
          rem_r <= trial - {1'b0, den_r};
          quo_r <= {quo_r[14:0], 1'b1};
        end else begin
          rem_r <= trial;
          quo_r <= {quo_r[14:0], 1'b0};
        end
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Feature from the quotient, with the positive cap.
  always_comb begin
    if (neg_r) begin
      feat = 17'd32768 - {1'b0, quo_r};
    end else begin
      feat = 17'd32768 + {1'b0, quo_r};
    end
    if (feat > 17'd65535) begin
      feat = 17'd65535;
    end
  end

  // Result register.
  logic [15:0] first_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= cmd.emit;
    end
    if (cmd.feat_lo) begin
      first_r <= feat[15:0];
    end
    if (cmd.emit) begin
      out_data.feature_first  <= cmd.emit_oor ? 16'd0 : first_r;
      out_data.feature_second <= cmd.emit_oor ? 16'd0 : feat[15:0];
      out_data.out_of_range   <= cmd.emit_oor;
      out_data.last           <= cmd.emit_last;
    end
  end

  assign sts.npts     = npts_r;
  assign sts.oor      = oor_r;
  assign sts.div_done = done_r;

endmodule

FILE: rtl/dppdf_ctrl.sv
// Controller: sequences store reads, pair divisions and result transfers.
// Depends on dppdf_pkg.
module dppdf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start_ext,
  output logic               busy,
  output dppdf_pkg::dp_cmd_t cmd,
  input  dppdf_pkg::dp_sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic [3:0] pi_r, pi_nxt, pj_r, pj_nxt;
  logic       half_r, half_nxt;
  logic       lastpair;

  assign busy = (state_r != S_IDLE);
  assign lastpair = (pi_r == sts.npts - 4'd2) && (pj_r == sts.npts - 4'd1);

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    pi_nxt = pi_r;
    pj_nxt = pj_r;
    half_nxt = half_r;
    cmd = '0;
    cmd.rd_idx = idx_r;
    cmd.cap_idx = idx_r - 4'd1;
    cmd.pi = pi_r;
    cmd.pj = pj_r;
    unique case (state_r)
      S_IDLE: begin
        if (start_ext) begin
          cmd.load = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.oor) begin
          cmd.emit = 1'b1;
          cmd.emit_oor = 1'b1;
          cmd.emit_last = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        // Read point idx, capture the one read last cycle.
        cmd.rd_en = (idx_r < sts.npts);
        cmd.cap_en = (idx_r != 4'd0);
        idx_nxt = idx_r + 4'd1;
        if (idx_r == sts.npts) begin
          pi_nxt = 4'd0;
          pj_nxt = 4'd1;
          half_nxt = 1'b0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (sts.div_done) begin
          if (!half_r) begin
            cmd.feat_lo = 1'b1;
          end else begin
            cmd.emit = 1'b1;
            cmd.emit_last = lastpair;
          end
          half_nxt = !half_r;
          if (lastpair) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_DIV;
            if (pj_r == sts.npts - 4'd1) begin
              pi_nxt = pi_r + 4'd1;
              pj_nxt = pi_r + 4'd2;
            end else begin
              pj_nxt = pj_r + 4'd1;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    idx_r <= idx_nxt;
    pi_r <= pi_nxt;
    pj_r <= pj_nxt;
    half_r <= half_nxt;
  end

  // The pair indices stay ordered while dividing.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (pi_r < pj_r)) else $error("pair order");
  // A division is only started from the division state.
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> (state_r == S_DIV)) else $error("stray division");
  // An out-of-range result always ends the extraction.
  a_oor_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_oor |-> (cmd.emit_last && state_nxt == S_IDLE))
    else $error("oor not last");

endmodule

FILE: rtl/depth_patch_pair_difference_features.sv
// Depth patch pair-difference feature extractor, top level.
// An extraction runs a check state, then a read state for each of its n points plus one,
// then one division per feature in the shared serial divider, for four, five, nine or
// thirteen points; the next transfer may follow at once when busy drops. An out-of-range
// rectangle is flagged in the check state and strobed through the result register.
// Reset clears control state only; the store is undefined; the receiver cannot stall.
module depth_patch_pair_difference_features #(
  parameter int IMG_WIDTH  = dppdf_pkg::ImgWidth,
  parameter int IMG_HEIGHT = dppdf_pkg::ImgHeight,
  parameter int DEPTH_BITS = dppdf_pkg::DepthBits
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  dppdf_pkg::in_item_t  in_item,
  output logic                 out_strobe,
  output dppdf_pkg::out_item_t out_item,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data
);

  dppdf_pkg::dp_cmd_t cmd;
  dppdf_pkg::dp_sts_t sts;
  logic [1:0]  pattern_r;
  logic [15:0] sens_r;
  logic        accept;

  assign accept = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= dppdf_pkg::PAT_FOUR;
      sens_r    <= 16'd100;
    end else if (cfg_we) begin
      if (cfg_index == dppdf_pkg::REG_PATTERN) begin
        pattern_r <= cfg_data[1:0];
      end else begin
        sens_r <= cfg_data;
      end
    end
  end

  dppdf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .start_ext(accept && in_item.func == dppdf_pkg::FUNC_EXTRACT),
    .busy(busy), .cmd(cmd), .sts(sts)
  );

  dppdf_datapath #(
    .IMG_WIDTH(IMG_WIDTH), .IMG_HEIGHT(IMG_HEIGHT), .DEPTH_BITS(DEPTH_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n),
    .wr_en(accept && in_item.func == dppdf_pkg::FUNC_WRITE),
    .item(in_item), .pattern(pattern_r), .sens(sens_r),
    .cmd(cmd), .sts(sts), .out_strobe(out_strobe), .out_data(out_item)
  );

endmodule
